// ===== rtl/core/cht_pkg.sv =====
// ------------------------------------------------------------------------
// cht_pkg: chained hash table shared definitions
// sizes, command and status codes, controller/datapath interface types
// ------------------------------------------------------------------------
package cht_pkg;

	localparam int NUM_BUCKETS = 16;
	localparam int CHAIN_DEPTH = 8;

	localparam int KEY_W    = 31;
	localparam int CMD_W    = 2;
	localparam int STATUS_W = 3;
	localparam int BKT_OUT_W = 4;
	localparam int POS_OUT_W = 3;
	localparam int CFG_W    = 5;

	localparam logic [CFG_W-1:0] BUCKET_COUNT_RST = CFG_W'(16);

	localparam int BIDX_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam int POS_W  = (CHAIN_DEPTH > 1) ? $clog2(CHAIN_DEPTH) : 1;
	localparam int LEN_W  = $clog2(CHAIN_DEPTH + 1);
	localparam int DIV_W  = $clog2(NUM_BUCKETS + 1);
	localparam int CNT_W  = $clog2(KEY_W);
	localparam int MEM_DEPTH = NUM_BUCKETS * CHAIN_DEPTH;
	localparam int ADDR_W = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

	localparam logic [CMD_W-1:0] CMD_INSERT = CMD_W'(0);
	localparam logic [CMD_W-1:0] CMD_SEARCH = CMD_W'(1);
	localparam logic [CMD_W-1:0] CMD_DELETE = CMD_W'(2);

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED  = 3'd0,
		ST_FOUND     = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_DELETED   = 3'd3,
		ST_DEL_FAIL  = 3'd4,
		ST_FULL      = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MOD,
		S_DISPATCH,
		S_INS_RD,
		S_INS_WR,
		S_INS_FRONT,
		S_FIND_RD,
		S_FIND_CMP,
		S_DEL_RD,
		S_DEL_WR
	} state_t;

	typedef enum logic [2:0] {
		IDX_HOLD,
		IDX_LEN,
		IDX_ZERO,
		IDX_INC,
		IDX_DEC
	} idx_op_t;

	typedef enum logic [1:0] {
		SLOT_IDX,
		SLOT_PREV,
		SLOT_NEXT,
		SLOT_ZERO
	} slot_sel_t;

	typedef enum logic [1:0] {
		LEN_HOLD,
		LEN_INC,
		LEN_DEC
	} len_op_t;

	typedef enum logic [1:0] {
		POS_ZERO,
		POS_IDX,
		POS_HELD
	} pos_src_t;

	typedef struct packed {
		logic      load;
		logic      div_step;
		idx_op_t   idx_op;
		slot_sel_t slot_sel;
		logic      rd_en;
		logic      wr_en;
		logic      wr_key;
		len_op_t   len_op;
		logic      hold_pos;
		logic      finish;
		status_t   fin_status;
		pos_src_t  fin_pos;
	} ctrl_t;

	typedef struct packed {
		logic             div_last;
		logic [CMD_W-1:0] cmd;
		logic             len_full;
		logic             len_zero;
		logic             idx_is_one;
		logic             key_match;
		logic             last_find;
		logic             last_del;
	} stat_t;

endpackage

// ===== rtl/core/cht_ram.sv =====
// ------------------------------------------------------------------------
// cht_ram: generic single-port-write ram
// one write port, one read port, registered read data
// ------------------------------------------------------------------------
module cht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/core/cht_dp.sv =====
// ------------------------------------------------------------------------
// cht_dp: chained hash table datapath
// bit-serial modulo, chain lengths, key memory, result registers
// ------------------------------------------------------------------------
module cht_dp
	import cht_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [CMD_W-1:0]     command,
	input  logic [KEY_W-1:0]     key,
	input  logic                 cfg_we,
	input  logic [CFG_W-1:0]     bucket_count,
	input  ctrl_t                ctrl,
	output stat_t                stat,
	output logic                 done,
	output logic [STATUS_W-1:0]  status,
	output logic [BKT_OUT_W-1:0] bucket,
	output logic [POS_OUT_W-1:0] position
);

	logic [CFG_W-1:0]     bucket_count_q;
	logic [CMD_W-1:0]     cmd_q;
	logic [KEY_W-1:0]     key_q;
	logic [KEY_W-1:0]     div_q;
	logic [DIV_W-1:0]     rem_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [LEN_W-1:0]     idx_q;
	logic [POS_W-1:0]     pos_q;
	logic [LEN_W-1:0]     len_q [NUM_BUCKETS];
	logic                 done_q;
	logic [STATUS_W-1:0]  status_q;
	logic [BKT_OUT_W-1:0] bucket_q;
	logic [POS_OUT_W-1:0] position_q;

	logic [DIV_W-1:0]  eff_div;
	logic [DIV_W:0]    rem_shift;
	logic              rem_ge;
	logic [BIDX_W-1:0] bkt;
	logic [LEN_W-1:0]  len_cur;
	logic [POS_W-1:0]  slot;
	logic [ADDR_W-1:0] addr;
	logic [KEY_W-1:0]  rdata;
	logic [KEY_W-1:0]  wdata;

	// divisor clamped to 1..NUM_BUCKETS
	always_comb begin
		if (bucket_count_q == '0) begin
			eff_div = DIV_W'(1);
		end else if (int'(bucket_count_q) > NUM_BUCKETS) begin
			eff_div = DIV_W'(NUM_BUCKETS);
		end else begin
			eff_div = DIV_W'(bucket_count_q);
		end
	end

	assign rem_shift = {rem_q, div_q[KEY_W-1]};
	assign rem_ge    = (rem_shift >= {1'b0, eff_div});
	assign bkt       = BIDX_W'(rem_q);
	assign len_cur   = len_q[bkt];

	always_comb begin
		unique case (ctrl.slot_sel)
			SLOT_IDX:  slot = POS_W'(idx_q);
			SLOT_PREV: slot = POS_W'(idx_q - LEN_W'(1));
			SLOT_NEXT: slot = POS_W'(idx_q + LEN_W'(1));
			SLOT_ZERO: slot = '0;
			default:   slot = '0;
		endcase
	end

	assign addr  = ADDR_W'(bkt) * ADDR_W'(CHAIN_DEPTH) + ADDR_W'(slot);
	assign wdata = ctrl.wr_key ? key_q : rdata;

	cht_ram #(
		.WIDTH(KEY_W),
		.DEPTH(MEM_DEPTH)
	) u_keys (
		.clk  (clk),
		.we   (ctrl.wr_en),
		.waddr(addr),
		.wdata(wdata),
		.re   (ctrl.rd_en),
		.raddr(addr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= BUCKET_COUNT_RST;
		end else if (cfg_we) begin
			bucket_count_q <= bucket_count;
		end
	end

	// operand capture and restoring remainder, one key bit a cycle while div_step is high
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			cmd_q <= command;
			key_q <= key;
			div_q <= key;
			rem_q <= '0;
			cnt_q <= '0;
		end else if (ctrl.div_step) begin
			div_q <= div_q << 1;
			cnt_q <= cnt_q + CNT_W'(1);
			if (rem_ge) begin
				rem_q <= DIV_W'(rem_shift - {1'b0, eff_div});
			end else begin
				rem_q <= DIV_W'(rem_shift);
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctrl.idx_op)
			IDX_HOLD: idx_q <= idx_q;
			IDX_LEN:  idx_q <= len_cur;
			IDX_ZERO: idx_q <= '0;
			IDX_INC:  idx_q <= idx_q + LEN_W'(1);
			IDX_DEC:  idx_q <= idx_q - LEN_W'(1);
			default:  idx_q <= idx_q;
		endcase
		if (ctrl.hold_pos) begin
			pos_q <= POS_W'(idx_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BUCKETS; i++) begin
				len_q[i] <= '0;
			end
		end else begin
			unique case (ctrl.len_op)
				LEN_HOLD: ;
				LEN_INC:  len_q[bkt] <= len_cur + LEN_W'(1);
				LEN_DEC:  len_q[bkt] <= len_cur - LEN_W'(1);
				default:  ;
			endcase
		end
	end

	// result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctrl.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.finish) begin
			status_q <= ctrl.fin_status;
			bucket_q <= BKT_OUT_W'(bkt);
			unique case (ctrl.fin_pos)
				POS_ZERO: position_q <= '0;
				POS_IDX:  position_q <= POS_OUT_W'(idx_q);
				POS_HELD: position_q <= POS_OUT_W'(pos_q);
				default:  position_q <= '0;
			endcase
		end
	end

	assign stat.div_last   = (cnt_q == CNT_W'(KEY_W - 1));
	assign stat.cmd        = cmd_q;
	assign stat.len_full   = (len_cur == LEN_W'(CHAIN_DEPTH));
	assign stat.len_zero   = (len_cur == '0);
	assign stat.idx_is_one = (idx_q == LEN_W'(1));
	assign stat.key_match  = (rdata == key_q);
	assign stat.last_find  = (({1'b0, idx_q} + (LEN_W + 1)'(1)) == {1'b0, len_cur});
	assign stat.last_del   = (({1'b0, idx_q} + (LEN_W + 1)'(2)) == {1'b0, len_cur});

	assign done     = done_q;
	assign status   = status_q;
	assign bucket   = bucket_q;
	assign position = position_q;

endmodule

// ===== rtl/core/cht_ctrl.sv =====
// ------------------------------------------------------------------------
// cht_ctrl: chained hash table controller
// sequences modulo, chain walk and shifts for one command at a time
// ------------------------------------------------------------------------
module cht_ctrl
	import cht_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  stat_t stat,
	output logic  busy,
	output ctrl_t ctrl
);

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_nxt = S_MOD;
				end
			end
			S_MOD: begin
				if (stat.div_last) begin
					state_nxt = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (stat.cmd == CMD_INSERT) begin
					if (stat.len_full) begin
						state_nxt = S_IDLE;
					end else if (stat.len_zero) begin
						state_nxt = S_INS_FRONT;
					end else begin
						state_nxt = S_INS_RD;
					end
				end else if (stat.cmd == CMD_SEARCH || stat.cmd == CMD_DELETE) begin
					state_nxt = stat.len_zero ? S_IDLE : S_FIND_RD;
				end else begin
					state_nxt = S_IDLE;
				end
			end
			S_INS_RD:    state_nxt = S_INS_WR;
			S_INS_WR:    state_nxt = stat.idx_is_one ? S_INS_FRONT : S_INS_RD;
			S_INS_FRONT: state_nxt = S_IDLE;
			S_FIND_RD:   state_nxt = S_FIND_CMP;
			S_FIND_CMP: begin
				if (stat.key_match) begin
					if (stat.cmd == CMD_DELETE && !stat.last_find) begin
						state_nxt = S_DEL_RD;
					end else begin
						state_nxt = S_IDLE;
					end
				end else begin
					state_nxt = stat.last_find ? S_IDLE : S_FIND_RD;
				end
			end
			S_DEL_RD: state_nxt = S_DEL_WR;
			S_DEL_WR: state_nxt = stat.last_del ? S_IDLE : S_DEL_RD;
			default:  state_nxt = S_IDLE;
		endcase
	end

	// datapath commands
	always_comb begin
		ctrl            = '0;
		ctrl.idx_op     = IDX_HOLD;
		ctrl.slot_sel   = SLOT_IDX;
		ctrl.len_op     = LEN_HOLD;
		ctrl.fin_status = ST_NOT_FOUND;
		ctrl.fin_pos    = POS_ZERO;
		busy            = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				ctrl.load = start;
			end
			S_MOD: begin
				ctrl.div_step = 1'b1;
			end
			S_DISPATCH: begin
				if (stat.cmd == CMD_INSERT) begin
					if (stat.len_full) begin
						ctrl.finish     = 1'b1;
						ctrl.fin_status = ST_FULL;
					end else begin
						ctrl.idx_op = IDX_LEN;
					end
				end else if (stat.cmd == CMD_SEARCH || stat.cmd == CMD_DELETE) begin
					if (stat.len_zero) begin
						ctrl.finish     = 1'b1;
						ctrl.fin_status = (stat.cmd == CMD_DELETE) ? ST_DEL_FAIL : ST_NOT_FOUND;
					end else begin
						ctrl.idx_op = IDX_ZERO;
					end
				end else begin
					ctrl.finish = 1'b1;
				end
			end
			S_INS_RD: begin
				ctrl.rd_en    = 1'b1;
				ctrl.slot_sel = SLOT_PREV;
			end
			S_INS_WR: begin
				ctrl.wr_en  = 1'b1;
				ctrl.idx_op = IDX_DEC;
			end
			S_INS_FRONT: begin
				ctrl.wr_en      = 1'b1;
				ctrl.wr_key     = 1'b1;
				ctrl.slot_sel   = SLOT_ZERO;
				ctrl.len_op     = LEN_INC;
				ctrl.finish     = 1'b1;
				ctrl.fin_status = ST_INSERTED;
			end
			S_FIND_RD: begin
				ctrl.rd_en = 1'b1;
			end
			S_FIND_CMP: begin
				if (stat.key_match) begin
					if (stat.cmd == CMD_DELETE) begin
						if (stat.last_find) begin
							ctrl.len_op     = LEN_DEC;
							ctrl.finish     = 1'b1;
							ctrl.fin_status = ST_DELETED;
							ctrl.fin_pos    = POS_IDX;
						end else begin
							ctrl.hold_pos = 1'b1;
						end
					end else begin
						ctrl.finish     = 1'b1;
						ctrl.fin_status = ST_FOUND;
						ctrl.fin_pos    = POS_IDX;
					end
				end else if (stat.last_find) begin
					ctrl.finish     = 1'b1;
					ctrl.fin_status = (stat.cmd == CMD_DELETE) ? ST_DEL_FAIL : ST_NOT_FOUND;
				end else begin
					ctrl.idx_op = IDX_INC;
				end
			end
			S_DEL_RD: begin
				ctrl.rd_en    = 1'b1;
				ctrl.slot_sel = SLOT_NEXT;
			end
			S_DEL_WR: begin
				ctrl.wr_en  = 1'b1;
				ctrl.idx_op = IDX_INC;
				if (stat.last_del) begin
					ctrl.len_op     = LEN_DEC;
					ctrl.finish     = 1'b1;
					ctrl.fin_status = ST_DELETED;
					ctrl.fin_pos    = POS_HELD;
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== rtl/core/chained_hash_table_top.sv =====
// ------------------------------------------------------------------------
// chained_hash_table_top: hash table with bounded chains
// division-method buckets, insert at front, search and delete of the
// first match from the front, one result per command
// ------------------------------------------------------------------------
//
//  channel   ports                           transfer
//  --------  ------------------------------  -------------------------------
//  command   start, command, key   -> busy   edge with start high, busy low
//  result    done, status, bucket, position  edge ending the done cycle
//  config    cfg_we, bucket_count            edge with cfg_we high
//
//  a command runs from its transfer to its done cycle through 31 modulo
//  steps, one dispatch, then a read and a write or compare per chain entry
//  (insert shifts all, none if full; search stops at a hit; delete: all)
//  arst_n clears chain lengths and sets bucket_count to 16; the key ram
//  needs no clearing, an entry past a chain's length is never read
//  done strobes for one cycle and cannot stall; a new command may start then
//
module chained_hash_table_top
	import cht_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// command transfer
	input  logic                 start,
	output logic                 busy,
	input  logic [CMD_W-1:0]     command,
	input  logic [KEY_W-1:0]     key,
	// bucket count register
	input  logic                 cfg_we,
	input  logic [CFG_W-1:0]     bucket_count,
	// result strobe
	output logic                 done,
	output logic [STATUS_W-1:0]  status,
	output logic [BKT_OUT_W-1:0] bucket,
	output logic [POS_OUT_W-1:0] position
);

	ctrl_t ctrl;
	stat_t stat;

	// sequencer: one command at a time
	cht_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.stat  (stat),
		.busy  (busy),
		.ctrl  (ctrl)
	);

	// modulo unit, chain lengths, key ram and result registers
	cht_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.command     (command),
		.key         (key),
		.cfg_we      (cfg_we),
		.bucket_count(bucket_count),
		.ctrl        (ctrl),
		.stat        (stat),
		.done        (done),
		.status      (status),
		.bucket      (bucket),
		.position    (position)
	);

endmodule

// ===== rtl/core/cht_checker.sv =====
// ------------------------------------------------------------------------
// cht_checker: port-level checks for the chained hash table
// command/result sequencing and result field consistency
// ------------------------------------------------------------------------
module cht_checker
	import cht_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 start,
	input logic                 busy,
	input logic                 done,
	input logic [STATUS_W-1:0]  status,
	input logic [POS_OUT_W-1:0] position
);

	// an accepted command keeps the block busy
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("command transfer not followed by busy");

	// a result is shown only once the block is free
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// a command does not end without a result
	a_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status <= STATUS_W'(ST_FULL)))
		else $error("status code out of range");

	// only found and deleted report a position
	a_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == STATUS_W'(ST_INSERTED) || status == STATUS_W'(ST_NOT_FOUND)
			|| status == STATUS_W'(ST_DEL_FAIL) || status == STATUS_W'(ST_FULL))
		|-> (position == '0))
		else $error("nonzero position on a result without a match");

endmodule

bind chained_hash_table_top cht_checker u_checker (.*);
